// ===== sv/tmq_pkg.sv =====
// shared types, codes and time helpers for the timed sorted message queue
`default_nettype none
package tmq_pkg;

  localparam int TIME_W = 64;
  localparam int SIZE_W = 32;
  localparam int FUNC_W = 2;
  localparam int TAGIN_W = 16;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_POP    = 2'd1;
  localparam func_t FUNC_UPDATE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start_search;
    logic search_step;
    logic place;
    logic pop;
    logic update;
    logic prop_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_pop;
    logic is_update;
    logic full;
    logic empty;
    logic search_more;
    logic prop_more;
    logic out_free;
  } status_t;

  // saturating time sum
  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic time_t max_time(time_t a, time_t b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tmq_if.sv =====
// request, result and configuration channels
`default_nettype none
interface tmq_req_if;
  import tmq_pkg::*;
  logic valid;
  logic ready;
  func_t func;
  time_t now_time;
  time_t deadline;
  size_t msg_size;
  logic [TAGIN_W-1:0] msg_tag;
  modport source (output valid, func, now_time, deadline, msg_size, msg_tag, input ready);
  modport sink (input valid, func, now_time, deadline, msg_size, msg_tag, output ready);
endinterface

interface tmq_rsp_if #(parameter int TAG_WIDTH = 16, parameter int CW = 5);
  import tmq_pkg::*;
  logic valid;
  logic ready;
  logic accepted;
  logic out_valid;
  logic [TAG_WIDTH-1:0] out_tag;
  time_t out_due_time;
  time_t out_arrival_time;
  size_t out_size;
  logic late;
  logic [CW-1:0] queue_count;
  logic empty_res;
  modport source (output valid, accepted, out_valid, out_tag, out_due_time,
                  out_arrival_time, out_size, late, queue_count, empty_res, input ready);
  modport sink (input valid, accepted, out_valid, out_tag, out_due_time,
                out_arrival_time, out_size, late, queue_count, empty_res, output ready);
endinterface

interface tmq_cfg_if;
  logic valid;
  logic ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/tmq_ctrl.sv =====
// controller state machine sequencing search, placement and push-back
`default_nettype none
module tmq_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_fire,
  output logic req_ready,
  input  tmq_pkg::status_t st,
  output tmq_pkg::cmd_t cmd
);
  import tmq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SEARCH = 5'b00100,
    S_PROP   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_fire) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_insert && !st.full) begin
          cmd.start_search = 1'b1;
          state_next = S_SEARCH;
        end else if (st.is_pop && !st.empty) begin
          cmd.pop = 1'b1;
          state_next = S_DONE;
        end else if (st.is_update && !st.empty) begin
          cmd.update = 1'b1;
          state_next = S_PROP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SEARCH: begin
        if (st.search_more) cmd.search_step = 1'b1;
        else begin
          cmd.place = 1'b1;
          state_next = S_PROP;
        end
      end
      S_PROP: begin
        if (st.prop_more) cmd.prop_step = 1'b1;
        else state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/tmq_dp.sv =====
// datapath: entry stores, walk pointer, running end time and result register
`default_nettype none
module tmq_dp #(
  parameter int DEPTH = 16,
  parameter int TAG_WIDTH = 16,
  parameter int CW = 5
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_fire,
  input  tmq_pkg::func_t func,
  input  tmq_pkg::time_t now_time,
  input  tmq_pkg::time_t deadline,
  input  tmq_pkg::size_t msg_size,
  input  wire logic [tmq_pkg::TAGIN_W-1:0] msg_tag,
  input  wire logic cfg_fire,
  input  wire logic [31:0] cfg_data,
  input  tmq_pkg::cmd_t cmd,
  output tmq_pkg::status_t st,
  input  wire logic rsp_ready,
  output logic rsp_valid,
  output logic accepted,
  output logic out_valid,
  output logic [TAG_WIDTH-1:0] out_tag,
  output tmq_pkg::time_t out_due_time,
  output tmq_pkg::time_t out_arrival_time,
  output tmq_pkg::size_t out_size,
  output logic late,
  output logic [CW-1:0] queue_count,
  output logic empty_res
);
  import tmq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  // entry stores, one register per entry
  time_t due_q [DEPTH];
  time_t arr_q [DEPTH];
  size_t size_q [DEPTH];
  logic [TAG_WIDTH-1:0] tag_q [DEPTH];
  logic [CW-1:0] count;
  logic [31:0] late_limit;

  // latched request
  func_t r_func;
  time_t r_now, r_due;
  size_t r_size;
  logic [TAG_WIDTH-1:0] r_tag;

  logic [CW-1:0] ptr;
  time_t run_end;

  // pending result
  logic res_acc, res_valid, res_late;
  logic [TAG_WIDTH-1:0] res_tag;
  time_t res_due, res_arr;
  size_t res_size;

  logic [IW-1:0] ix;
  logic in_range;
  time_t start, head_max;
  logic raise;

  // selected entry at the walk pointer
  assign ix = ptr[IW-1:0];
  assign in_range = ptr < count;
  assign start = max_time(max_time(run_end, r_now), r_due);
  assign raise = r_now > arr_q[0];
  assign head_max = raise ? r_now : arr_q[0];

  // status to controller
  always_comb begin
    st.is_insert = r_func == FUNC_INSERT;
    st.is_pop = r_func == FUNC_POP;
    st.is_update = r_func == FUNC_UPDATE;
    st.full = count == CW'(DEPTH);
    st.empty = count == '0;
    st.search_more = in_range && (due_q[ix] < r_due);
    st.prop_more = in_range && (arr_q[ix] < run_end);
    st.out_free = !rsp_valid || rsp_ready;
  end

  // late limit register
  always_ff @(posedge clk) begin
    if (rst) late_limit <= '0;
    else if (cfg_fire) late_limit <= cfg_data;
  end

  // request latch
  always_ff @(posedge clk) begin
    if (req_fire) begin
      r_func <= func;
      r_now <= now_time;
      r_due <= deadline;
      r_size <= msg_size;
      r_tag <= msg_tag[TAG_WIDTH-1:0];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.place) count <= count + 1'b1;
    else if (cmd.pop) count <= count - 1'b1;
  end

  // walk pointer and running end time
  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      ptr <= '0;
      run_end <= '0;
    end else if (cmd.search_step) begin
      ptr <= ptr + 1'b1;
      run_end <= sat_add(arr_q[ix], TIME_W'(size_q[ix]));
    end else if (cmd.place) begin
      ptr <= ptr + 1'b1;
      run_end <= sat_add(start, TIME_W'(r_size));
    end else if (cmd.update) begin
      ptr <= CW'(1);
      run_end <= sat_add(head_max, TIME_W'(size_q[0]));
    end else if (cmd.prop_step) begin
      ptr <= ptr + 1'b1;
      run_end <= sat_add(run_end, TIME_W'(size_q[ix]));
    end
  end

  // entry stores: shift up on insert, down on pop, single writes otherwise
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.place) begin
        if (CW'(i) == ptr) begin
          due_q[i] <= r_due;
          arr_q[i] <= start;
          size_q[i] <= r_size;
          tag_q[i] <= r_tag;
        end else if (i > 0 && CW'(i) > ptr && CW'(i) <= count) begin
          due_q[i] <= due_q[(i+DEPTH-1)%DEPTH];
          arr_q[i] <= arr_q[(i+DEPTH-1)%DEPTH];
          size_q[i] <= size_q[(i+DEPTH-1)%DEPTH];
          tag_q[i] <= tag_q[(i+DEPTH-1)%DEPTH];
        end
      end else if (cmd.pop) begin
        if (i < DEPTH-1) begin
          due_q[i] <= due_q[(i+1)%DEPTH];
          arr_q[i] <= arr_q[(i+1)%DEPTH];
          size_q[i] <= size_q[(i+1)%DEPTH];
          tag_q[i] <= tag_q[(i+1)%DEPTH];
        end
      end else if (cmd.update) begin
        if (i == 0 && raise) arr_q[i] <= r_now;
      end else if (cmd.prop_step) begin
        if (CW'(i) == ptr) arr_q[i] <= run_end;
      end
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_acc <= 1'b0;
      res_valid <= 1'b0;
      res_late <= 1'b0;
      res_tag <= '0;
      res_due <= '0;
      res_arr <= '0;
      res_size <= '0;
    end else if (cmd.pop) begin
      res_acc <= 1'b1;
      res_valid <= 1'b1;
      res_tag <= tag_q[0];
      res_due <= due_q[0];
      res_arr <= arr_q[0];
      res_size <= size_q[0];
    end else if (cmd.place) begin
      res_acc <= 1'b1;
    end else if (cmd.update) begin
      res_acc <= 1'b1;
      res_late <= raise && (r_now > sat_add(due_q[0], TIME_W'(late_limit)));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.commit) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      accepted <= res_acc;
      out_valid <= res_valid;
      out_tag <= res_tag;
      out_due_time <= res_due;
      out_arrival_time <= res_arr;
      out_size <= res_size;
      late <= res_late;
      queue_count <= count;
      empty_res <= count == '0;
    end
  end
endmodule
`default_nettype wire

// ===== sv/timed_sorted_message_queue_core.sv =====
// top level of the timed sorted message queue
// A queue of up to DEPTH messages kept in due-time order. Each request (insert, pop,
// update time) gives one result. A pop, or any request that has no effect, goes from
// decode straight to the done state and loads its result into the output register;
// an update first walks the entries it pushes back, and an insert the entries searched
// before its position and then those pushed back, one entry per cycle through the
// single walk pointer. The next request is taken in the cycle after the result is
// loaded, while that result still waits in the output register; a result that is not
// taken holds the next one back.
// The late_limit register is written over the cfg channel, which is always ready.
`default_nettype none
module timed_sorted_message_queue_core #(
  parameter int DEPTH = 16,
  parameter int TAG_WIDTH = 16,
  parameter int CW = 5
) (
  input wire logic clk,
  input wire logic rst,
  tmq_req_if.sink req_in,
  tmq_rsp_if.source rsp_out,
  tmq_cfg_if.sink cfg
);
  import tmq_pkg::*;

  cmd_t cmd;
  status_t st;
  logic req_fire;

  // handshakes
  assign req_fire = req_in.valid && req_in.ready;
  assign cfg.ready = 1'b1;

  tmq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_fire(req_fire), .req_ready(req_in.ready),
    .st(st), .cmd(cmd)
  );

  tmq_dp #(.DEPTH(DEPTH), .TAG_WIDTH(TAG_WIDTH), .CW(CW)) u_dp (
    .clk(clk), .rst(rst), .req_fire(req_fire),
    .func(req_in.func), .now_time(req_in.now_time),
    .deadline(req_in.deadline), .msg_size(req_in.msg_size), .msg_tag(req_in.msg_tag),
    .cfg_fire(cfg.valid), .cfg_data(cfg.data),
    .cmd(cmd), .st(st),
    .rsp_ready(rsp_out.ready), .rsp_valid(rsp_out.valid),
    .accepted(rsp_out.accepted), .out_valid(rsp_out.out_valid),
    .out_tag(rsp_out.out_tag), .out_due_time(rsp_out.out_due_time),
    .out_arrival_time(rsp_out.out_arrival_time), .out_size(rsp_out.out_size),
    .late(rsp_out.late), .queue_count(rsp_out.queue_count),
    .empty_res(rsp_out.empty_res)
  );
endmodule
`default_nettype wire

// ===== sv/tmq_checker.sv =====
// port-level checker for the timed sorted message queue, with its bind
`default_nettype none
module tmq_checker #(parameter int TAG_WIDTH = 16, parameter int CW = 5) (
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic accepted,
  input wire logic out_valid,
  input wire logic [TAG_WIDTH-1:0] out_tag,
  input wire logic [63:0] out_due_time,
  input wire logic late,
  input wire logic [CW-1:0] queue_count,
  input wire logic empty_res
);
  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (empty_res == (queue_count == '0))) else $error("empty_res mismatch");

  // a popped message or late flag only on a request that took effect
  a_acc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (out_valid || late) |-> accepted) else $error("unaccepted result");

  // a pop never reports late
  a_pop_late: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_valid |-> !late) else $error("late on pop");

  // no popped message means cleared message fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_valid |-> (out_tag == '0 && out_due_time == '0))
    else $error("stale message fields");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(queue_count))
    else $error("result dropped");
endmodule

bind timed_sorted_message_queue_core tmq_checker #(.TAG_WIDTH(TAG_WIDTH), .CW(CW)) u_chk (
  .clk(clk), .rst(rst), .rsp_valid(rsp_out.valid), .rsp_ready(rsp_out.ready),
  .accepted(rsp_out.accepted), .out_valid(rsp_out.out_valid), .out_tag(rsp_out.out_tag),
  .out_due_time(rsp_out.out_due_time), .late(rsp_out.late),
  .queue_count(rsp_out.queue_count), .empty_res(rsp_out.empty_res)
);
`default_nettype wire

// ===== dv/timed_sorted_message_queue_core_tb.sv =====
// testbench for the timed sorted message queue: directed table, then random requests
`default_nettype none
module timed_sorted_message_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CW = 5;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam time_t TMAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic accepted;
    logic out_valid;
    logic [15:0] out_tag;
    time_t out_due_time;
    time_t out_arrival_time;
    size_t out_size;
    logic late;
    logic [CW-1:0] queue_count;
    logic empty_res;
  } result_t;

  typedef struct packed {
    func_t func;
    time_t now_t;
    time_t due;
    size_t size;
    logic [15:0] tag;
    logic has_fixed;
    result_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  tmq_req_if req_ch ();
  tmq_rsp_if #(.TAG_WIDTH(16), .CW(CW)) rsp_ch ();
  tmq_cfg_if cfg_ch ();

  timed_sorted_message_queue_core #(.DEPTH(DEPTH), .TAG_WIDTH(16), .CW(CW)) u_dut (
    .clk(clk), .rst(rst), .req_in(req_ch.sink), .rsp_out(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  // predictor state
  time_t q_due[DEPTH];
  time_t q_arr[DEPTH];
  size_t q_size[DEPTH];
  logic [15:0] q_tag[DEPTH];
  int q_count = 0;
  logic [31:0] lateness_limit = 0;

  result_t pending_results[$];
  result_t fixed_results[$];
  logic fixed_flags[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_rsp = 0;
  bit timed_out = 0;
  bit sender_done = 0;

  function automatic time_t sadd(time_t a, time_t b);
    time_t s;
    s = a + b;
    return (s < a) ? TMAX : s;
  endfunction

  // push back entries from pos on while they overlap their predecessor
  function automatic void push_back_from(int pos, time_t link_end);
    while (pos < q_count && q_arr[pos] < link_end) begin
      q_arr[pos] = link_end;
      link_end = sadd(link_end, {32'd0, q_size[pos]});
      pos++;
    end
  endfunction

  // compute result of one request and update the queue model
  function automatic result_t predict_queue_op(func_t f, time_t now_t, time_t due, size_t size,
                                               logic [15:0] tag);
    result_t r;
    int pos;
    time_t start;
    r = '0;
    if (f == FUNC_INSERT && q_count < DEPTH) begin
      pos = 0;
      while (pos < q_count && q_due[pos] < due) pos++;
      start = (pos == 0) ? '0 : sadd(q_arr[pos-1], {32'd0, q_size[pos-1]});
      if (now_t > start) start = now_t;
      if (due > start) start = due;
      for (int i = q_count; i > pos; i--) begin
        q_due[i] = q_due[i-1]; q_arr[i] = q_arr[i-1];
        q_size[i] = q_size[i-1]; q_tag[i] = q_tag[i-1];
      end
      q_due[pos] = due; q_arr[pos] = start; q_size[pos] = size; q_tag[pos] = tag;
      q_count++;
      push_back_from(pos + 1, sadd(start, {32'd0, size}));
      r.accepted = 1'b1;
    end else if (f == FUNC_POP && q_count > 0) begin
      r.out_valid = 1'b1;
      r.out_tag = q_tag[0]; r.out_due_time = q_due[0];
      r.out_arrival_time = q_arr[0]; r.out_size = q_size[0];
      for (int i = 1; i < q_count; i++) begin
        q_due[i-1] = q_due[i]; q_arr[i-1] = q_arr[i];
        q_size[i-1] = q_size[i]; q_tag[i-1] = q_tag[i];
      end
      q_count--;
      r.accepted = 1'b1;
    end else if (f == FUNC_UPDATE && q_count > 0) begin
      if (now_t > q_arr[0]) begin
        if (now_t > sadd(q_due[0], {32'd0, lateness_limit})) r.late = 1'b1;
        q_arr[0] = now_t;
      end
      push_back_from(1, sadd(q_arr[0], {32'd0, q_size[0]}));
      r.accepted = 1'b1;
    end
    r.queue_count = q_count[CW-1:0];
    r.empty_res = (q_count == 0);
    return r;
  endfunction

  // drive one request after a random gap and record its expectation
  task automatic send_request(func_t f, time_t now_t, time_t due, size_t size,
                              logic [15:0] tag, logic has_fixed, result_t fixed, int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.now_time <= now_t;
    req_ch.deadline <= due;
    req_ch.msg_size <= size;
    req_ch.msg_tag <= tag;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_queue_op(f, now_t, due, size, tag));
    fixed_results.push_back(fixed);
    fixed_flags.push_back(has_fixed);
  endtask

  task automatic write_limit(logic [31:0] value);
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    lateness_limit = value;
  endtask

  function automatic time_t rand_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TMAX - $urandom_range(0, 200);
      2: return {$urandom, $urandom};
      default: return {32'd0, $urandom_range(0, 4000)};
    endcase
  endfunction

  function automatic size_t rand_size();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // result checker with random stalls
  always @(posedge clk) begin
    result_t got, want;
    logic fx;
    result_t fexp;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.accepted, rsp_ch.out_valid, rsp_ch.out_tag, rsp_ch.out_due_time,
                rsp_ch.out_arrival_time, rsp_ch.out_size, rsp_ch.late,
                rsp_ch.queue_count, rsp_ch.empty_res};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_results.pop_front();
          fx = fixed_flags.pop_front();
          fexp = fixed_results.pop_front();
          if (fx && fexp != want) begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees: table %p model %p", fexp, want);
          end
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_rsp > 0) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 16) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (hold_rsp > 0) hold_rsp <= hold_rsp - 1;
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timed_sorted_message_queue_core test failed");
      $finish;
    end
  end

  function automatic result_t plain(logic acc, int cnt);
    result_t r;
    r = '0;
    r.accepted = acc;
    r.queue_count = cnt[CW-1:0];
    r.empty_res = (cnt == 0);
    return r;
  endfunction

  initial begin
    row_t table_rows[$];
    row_t rw;
    result_t none;
    int gap;
    func_t f;
    none = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_INSERT;
    req_ch.now_time = '0;
    req_ch.deadline = '0;
    req_ch.msg_size = '0;
    req_ch.msg_tag = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: empty-queue cases, extremes, ties, saturation, full queue
    table_rows.push_back('{FUNC_POP, '0, '0, '0, 16'h0, 1'b1, plain(0, 0)});
    table_rows.push_back('{FUNC_UPDATE, 64'd5, '0, '0, 16'h0, 1'b1, plain(0, 0)});
    table_rows.push_back('{FUNC_UNUSED, TMAX, TMAX, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, plain(0, 0)});
    table_rows.push_back('{FUNC_INSERT, 64'd10, 64'd100, 32'd20, 16'h0001, 1'b1, plain(1, 1)});
    table_rows.push_back('{FUNC_INSERT, 64'd0, 64'd100, 32'd5, 16'h0002, 1'b0, none});
    table_rows.push_back('{FUNC_INSERT, 64'd0, 64'd50, 32'd60, 16'h0003, 1'b0, none});
    table_rows.push_back('{FUNC_UPDATE, 64'd500, '0, '0, 16'h0, 1'b0, none});
    table_rows.push_back('{FUNC_UPDATE, 64'd1, '0, '0, 16'h0, 1'b0, none});
    table_rows.push_back('{FUNC_INSERT, TMAX, TMAX, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, none});
    table_rows.push_back('{FUNC_INSERT, '0, TMAX - 3, 32'hFFFF_FFFF, 16'h8000, 1'b0, none});
    table_rows.push_back('{FUNC_UNUSED, '0, '0, '0, 16'h0, 1'b0, none});
    for (int i = 0; i < 13; i++)
      table_rows.push_back('{FUNC_INSERT, 64'd7, 64'(i * 3), 32'(i), 16'(i + 16'h100),
                             1'b0, none});
    table_rows.push_back('{FUNC_INSERT, '0, '0, '0, 16'h5555, 1'b1, plain(0, 16)});
    for (int i = 0; i < 5; i++)
      table_rows.push_back('{FUNC_POP, '0, '0, '0, 16'h0, 1'b0, none});
    foreach (table_rows[i]) begin
      rw = table_rows[i];
      send_request(rw.func, rw.now_t, rw.due, rw.size, rw.tag, rw.has_fixed, rw.fixed, rand_gap());
    end
    while (q_count > 0) send_request(FUNC_POP, '0, '0, '0, '0, 1'b0, none, rand_gap());

    // random phases over several late_limit settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_limit(32'd0);
        1: write_limit(32'hFFFF_FFFF);
        2: write_limit($urandom_range(0, 500));
        default: write_limit($urandom);
      endcase
      if (ph == 1) hold_rsp <= 400;
      for (int n = 0; n < 150; n++) begin
        case ($urandom_range(0, 19))
          0: f = FUNC_UNUSED;
          1, 2, 3, 4, 5, 6, 7, 8: f = FUNC_INSERT;
          9, 10, 11, 12, 13: f = FUNC_POP;
          default: f = FUNC_UPDATE;
        endcase
        gap = (ph == 1 && n < 60) ? 0 : rand_gap();
        send_request(f, rand_time(), rand_time(), rand_size(), 16'($urandom), 1'b0, none, gap);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("timed_sorted_message_queue_core test passed");
    end else begin
      $display("timed_sorted_message_queue_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
